@@ hdl/kvlp_pkg.sv @@
package kvlp_pkg;

    localparam int KEY_LIMIT_DEF = 32;

    localparam int LIMIT_W     = 11;
    localparam int ENTRY_W     = 10;
    localparam int VALUE_W     = 64;
    localparam int CHUNK_W     = 64;
    localparam int CNT_W       = 4;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 144;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd64;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [2:0] PH_KEY     = 3'd0;
    localparam logic [2:0] PH_SPACE   = 3'd1;
    localparam logic [2:0] PH_DIGITS  = 3'd2;
    localparam logic [2:0] PH_TAIL    = 3'd3;
    localparam logic [2:0] PH_DISCARD = 3'd4;

endpackage

@@ hdl/key_value_line_parser.sv @@
// A line-ending byte is first captured in the input register; when it is consumed, its entry is
// loaded into the flush register, which presents the first key chunk on the output.
// Throughput: one text byte per cycle; an entry leaves as ceil(key_length/8) chunks (at
// least one), one per cycle while the receiver is ready. Input stalls only when a line ends
// while the chunks of the previous entry are still waiting in the flush register.
// Reset: synchronous, active low; clears line state, entry count and sets entry_limit to 64.
module key_value_line_parser #(
    parameter int KEY_LIMIT = kvlp_pkg::KEY_LIMIT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [kvlp_pkg::LIMIT_W-1:0]     i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [kvlp_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // text_byte[7:0]
    input  logic                             s_axis_tlast,  // end_of_text
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // key_chunk[63:0], chunk_bytes[67:64], entry_number[77:68], value_number[141:78], zeros
    output logic [kvlp_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tlast   // last_chunk
);
    import kvlp_pkg::*;

    localparam int LW   = $clog2(KEY_LIMIT);
    localparam int FL_W = ((KEY_LIMIT + 7) / 8) * 64;
    localparam logic [LW-1:0] KLEN_MAX = LW'(KEY_LIMIT - 1);

    // input register
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;

    // line state
    logic [LIMIT_W-1:0]  r_limit;
    logic [2:0]          r_phase, n_phase;
    logic [LW-1:0]       r_klen, n_klen;
    logic [VALUE_W-1:0]  r_acc, n_acc;
    logic [VALUE_W-1:0]  r_nacc, n_nacc;
    logic                r_ovf, n_ovf;
    logic                r_neg, n_neg;
    logic [LIMIT_W-1:0]  r_ent, n_ent;
    logic [7:0]          r_key [KEY_LIMIT];

    // flush register
    logic                r_fl_busy;
    logic [FL_W-1:0]     r_fl_key;
    logic [LW-1:0]       r_fl_rem;
    logic [ENTRY_W-1:0]  r_fl_entry;
    logic [VALUE_W-1:0]  r_fl_value;

    logic [2:0]          u_phase;
    logic [LW-1:0]       u_klen;
    logic [VALUE_W-1:0]  u_acc, u_nacc;
    logic                u_ovf, u_neg;
    logic                w_key_we;
    logic                w_is_nul, w_is_nl, w_is_digit, w_is_space, w_fin, w_emit;
    logic [3:0]          w_digit;
    logic [VALUE_W+3:0]  w_prod;
    logic [VALUE_W-1:0]  w_nprod;
    logic [VALUE_W-1:0]  w_val;
    logic [FL_W-1:0]     w_key_flat;
    logic                w_cons, w_load, w_load_ok, w_out_acc, w_last;
    logic [6:0]          w_rem7;
    logic [CNT_W-1:0]    w_cnt;
    logic [CHUNK_W-1:0]  w_chunk;

    assign o_cfg_ready = 1'b1;

    assign w_is_nul   = (r_in_byte == CH_NUL);
    assign w_is_nl    = (r_in_byte == CH_NL);
    assign w_is_digit = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);
    assign w_is_space = (r_in_byte == CH_SPACE) || (r_in_byte == CH_TAB) ||
                        (r_in_byte == CH_VT) || (r_in_byte == CH_FF) ||
                        (r_in_byte == CH_CR);
    assign w_digit    = r_in_byte[3:0];

    assign w_prod  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + (VALUE_W+4)'(w_digit);
    assign w_nprod = {r_nacc[VALUE_W-4:0], 3'b000} + {r_nacc[VALUE_W-2:0], 1'b0}
                     - VALUE_W'(w_digit);

    always_comb begin
        u_phase  = r_phase;
        u_klen   = r_klen;
        u_acc    = r_acc;
        u_nacc   = r_nacc;
        u_ovf    = r_ovf;
        u_neg    = r_neg;
        w_key_we = 1'b0;
        if (!w_is_nul && !w_is_nl) begin
            case (r_phase)
                PH_KEY: begin
                    if (r_in_byte == CH_COLON) begin
                        u_phase = PH_SPACE;
                    end else if (r_klen >= KLEN_MAX) begin
                        u_phase = PH_DISCARD;
                    end else begin
                        w_key_we = 1'b1;
                        u_klen   = r_klen + 1'b1;
                    end
                end
                PH_SPACE: begin
                    if (w_is_space) begin
                        u_phase = PH_SPACE;
                    end else if (r_in_byte == CH_PLUS) begin
                        u_phase = PH_DIGITS;
                    end else if (r_in_byte == CH_MINUS) begin
                        u_neg   = 1'b1;
                        u_phase = PH_DIGITS;
                    end else if (w_is_digit) begin
                        u_phase = PH_DIGITS;
                    end else begin
                        u_phase = PH_TAIL;
                    end
                end
                PH_DIGITS: begin
                    if (!w_is_digit) begin
                        u_phase = PH_TAIL;
                    end
                end
                default: begin
                    u_phase = r_phase;
                end
            endcase
            if (w_is_digit && !r_ovf && (r_phase == PH_SPACE || r_phase == PH_DIGITS)) begin
                if (w_prod[VALUE_W+3:VALUE_W] != 4'd0) begin
                    u_ovf = 1'b1;
                end else begin
                    u_acc  = w_prod[VALUE_W-1:0];
                    u_nacc = w_nprod;
                end
            end
        end
    end

    assign w_fin  = w_is_nul || w_is_nl || r_in_last;
    assign w_emit = w_fin && (r_ent < r_limit) &&
                    (u_phase == PH_SPACE || u_phase == PH_DIGITS || u_phase == PH_TAIL);
    assign w_val  = u_ovf ? {VALUE_W{1'b1}} : (u_neg ? u_nacc : u_acc);

    always_comb begin
        n_phase = w_fin ? PH_KEY : u_phase;
        n_klen  = w_fin ? '0 : u_klen;
        n_acc   = w_fin ? '0 : u_acc;
        n_nacc  = w_fin ? '0 : u_nacc;
        n_ovf   = w_fin ? 1'b0 : u_ovf;
        n_neg   = w_fin ? 1'b0 : u_neg;
        n_ent   = w_emit ? r_ent + 1'b1 : r_ent;
        if (w_is_nul || r_in_last) begin
            n_ent = '0;
        end
    end

    always_comb begin
        w_key_flat = '0;
        for (int i = 0; i < KEY_LIMIT; i++) begin
            w_key_flat[i*8 +: 8] = r_key[i];
        end
    end

    assign w_rem7    = 7'(r_fl_rem);
    assign w_last    = (w_rem7 <= 7'd8);
    assign w_cnt     = w_last ? CNT_W'(w_rem7) : CNT_W'(8);
    assign w_out_acc = r_fl_busy && m_axis_tready;
    assign w_load_ok = !r_fl_busy || (w_out_acc && w_last);
    assign w_cons    = r_in_valid && (!w_emit || w_load_ok);
    assign w_load    = w_cons && w_emit;

    assign s_axis_tready = !r_in_valid || w_cons;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_chunk[i*8 +: 8] = (CNT_W'(i) < w_cnt) ? r_fl_key[i*8 +: 8] : 8'h00;
        end
    end

    assign m_axis_tvalid = r_fl_busy;
    assign m_axis_tlast  = w_last;
    assign m_axis_tdata  = {2'b00, (w_last ? r_fl_value : {VALUE_W{1'b0}}),
                            r_fl_entry, w_cnt, w_chunk};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_limit    <= LIMIT_RESET;
            r_phase    <= PH_KEY;
            r_klen     <= '0;
            r_acc      <= '0;
            r_nacc     <= '0;
            r_ovf      <= 1'b0;
            r_neg      <= 1'b0;
            r_ent      <= '0;
            r_fl_busy  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_cons) begin
                r_in_valid <= 1'b0;
            end
            if (w_cons) begin
                r_phase <= n_phase;
                r_klen  <= n_klen;
                r_acc   <= n_acc;
                r_nacc  <= n_nacc;
                r_ovf   <= n_ovf;
                r_neg   <= n_neg;
                r_ent   <= n_ent;
            end
            if (w_load) begin
                r_fl_busy <= 1'b1;
            end else if (w_out_acc && w_last) begin
                r_fl_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (w_cons && w_key_we) begin
            r_key[r_klen] <= r_in_byte;
        end
        if (w_load) begin
            r_fl_key   <= w_key_flat;
            r_fl_rem   <= r_klen;
            r_fl_entry <= r_ent[ENTRY_W-1:0];
            r_fl_value <= w_val;
        end else if (w_out_acc && !w_last) begin
            r_fl_key <= r_fl_key >> 64;
            r_fl_rem <= LW'(w_rem7 - 7'd8);
        end
    end

`ifndef SYNTHESIS
    a_full_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[67:64] == 4'd8))
        else $error("non-final chunk not full");

    a_value_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[141:78] == '0))
        else $error("value on non-final chunk");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast && !w_load) |=> !m_axis_tvalid)
        else $error("flush register still busy after final chunk");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_fl_busy) |-> (m_axis_tready && w_last))
        else $error("entry loaded over pending chunks");

    a_key_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_cons) |=> (r_klen <= KLEN_MAX))
        else $error("key length beyond limit");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import kvlp_pkg::*;

    localparam int KEY_MAX     = KEY_LIMIT_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int FILL_LINES  = 10;

    typedef struct packed {
        logic [63:0] key;
        logic [3:0]  nbytes;
        logic [9:0]  entry;
        logic [63:0] value;
        logic        last;
    } t_kv_chunk;

    typedef struct {
        string       text;
        bit          eot;
        bit          close_doc;
        bit          pinned;
        logic [63:0] pin_key;
        logic [3:0]  pin_bytes;
        logic [63:0] pin_value;
    } t_text_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [LIMIT_W-1:0]   i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    key_value_line_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // line parser shadow state
    logic [2:0]         ln_phase;
    logic [7:0]         key_buf [KEY_MAX];
    int                 key_len;
    logic [63:0]        acc;
    logic               acc_ovf;
    logic               acc_neg;
    logic [LIMIT_W-1:0] doc_entries;
    logic [LIMIT_W-1:0] entry_limit;

    t_kv_chunk   expected_chunks [$];
    bit          pin_set;
    t_kv_chunk   pin_chunk;
    logic [7:0]  line_buf [$];
    logic [7:0]  ws_set [5] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_go = 1'b0;
    logic        hold_on = 1'b0;
    int          cycles = 0;
    int          bytes_sent = 0;
    int          chunks_predicted = 0;
    int          chunks_checked = 0;
    int          mismatches = 0;
    t_kv_chunk   rx_got;
    t_kv_chunk   rx_exp;

    t_text_row dir_rows [20] = '{
        '{"ab:5\n", 1'b0, 1'b0, 1'b1, 64'h6261, 4'd2, 64'd5},
        '{":\n", 1'b0, 1'b0, 1'b1, 64'h0, 4'd0, 64'd0},
        '{"x:-1\n", 1'b0, 1'b0, 1'b1, 64'h78, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF},
        '{"k:18446744073709551615\n", 1'b0, 1'b0, 1'b1, 64'h6b, 4'd1,
          64'hFFFF_FFFF_FFFF_FFFF},
        '{"k:18446744073709551616\n", 1'b0, 1'b0, 1'b1, 64'h6b, 4'd1,
          64'hFFFF_FFFF_FFFF_FFFF},
        '{"k:-99999999999999999999\n", 1'b0, 1'b0, 1'b1, 64'h6b, 4'd1,
          64'hFFFF_FFFF_FFFF_FFFF},
        '{"kk: \t\013\014\015+42xyz\n", 1'b0, 1'b0, 1'b1, 64'h6b6b, 4'd2, 64'd42},
        '{"s:-\n", 1'b0, 1'b0, 1'b1, 64'h73, 4'd1, 64'd0},
        '{"s: abc\n", 1'b0, 1'b0, 1'b1, 64'h73, 4'd1, 64'd0},
        '{"no colon here\n", 1'b0, 1'b0, 1'b0, 64'h0, 4'd0, 64'd0},
        '{"\n", 1'b0, 1'b0, 1'b0, 64'h0, 4'd0, 64'd0},
        '{"abcdefghijklmnopqrstuvwxyzABCDE:7\n", 1'b0, 1'b0, 1'b0, 64'h0, 4'd0, 64'd0},
        '{"abcdefghijklmnopqrstuvwxyzABCDEF:7\n", 1'b0, 1'b0, 1'b0, 64'h0, 4'd0, 64'd0},
        '{"abcdefghi:1\n", 1'b0, 1'b0, 1'b0, 64'h0, 4'd0, 64'd0},
        '{"a:1:2\n", 1'b0, 1'b0, 1'b0, 64'h0, 4'd0, 64'd0},
        '{"e:3", 1'b1, 1'b0, 1'b0, 64'h0, 4'd0, 64'd0},
        '{"f:4\n", 1'b0, 1'b1, 1'b0, 64'h0, 4'd0, 64'd0},
        '{"g:5\n", 1'b0, 1'b0, 1'b0, 64'h0, 4'd0, 64'd0},
        '{"h:6", 1'b0, 1'b1, 1'b0, 64'h0, 4'd0, 64'd0},
        '{"\377\200:8\n", 1'b0, 1'b0, 1'b0, 64'h0, 4'd0, 64'd0}
    };

    function void clear_line();
        ln_phase = PH_KEY;
        key_len  = 0;
        acc      = '0;
        acc_ovf  = 1'b0;
        acc_neg  = 1'b0;
    endfunction

    function void emit_entry();
        int        n_chunks;
        logic [63:0] val;
        t_kv_chunk c;
        if (ln_phase inside {PH_SPACE, PH_DIGITS, PH_TAIL} && doc_entries < entry_limit) begin
            n_chunks = (key_len + 7) / 8;
            if (n_chunks == 0) n_chunks = 1;
            if (acc_ovf) val = {64{1'b1}};
            else if (acc_neg) val = -acc;
            else val = acc;
            for (int k = 0; k < n_chunks; k++) begin
                c = '0;
                for (int i = 0; i < 8; i++) begin
                    if (k * 8 + i < key_len) begin
                        c.key[8*i +: 8] = key_buf[k * 8 + i];
                        c.nbytes = c.nbytes + 4'd1;
                    end
                end
                c.entry = doc_entries[9:0];
                c.last  = (k + 1 == n_chunks);
                c.value = c.last ? val : 64'd0;
                if (c.last && pin_set) begin
                    c.key    = pin_chunk.key;
                    c.nbytes = pin_chunk.nbytes;
                    c.value  = pin_chunk.value;
                    pin_set  = 1'b0;
                end
                expected_chunks.push_back(c);
                chunks_predicted++;
            end
            doc_entries = doc_entries + 1'b1;
        end
        clear_line();
    endfunction

    function void add_digit(input logic [7:0] b);
        logic [63:0] d;
        d = {56'd0, b - CH_ZERO};
        if (acc_ovf) return;
        if (acc > ({64{1'b1}} - d) / 64'd10) acc_ovf = 1'b1;
        else acc = acc * 64'd10 + d;
    endfunction

    function void predict_text_byte(input logic [7:0] b, input logic eot);
        if (b == CH_NUL) begin
            emit_entry();
            doc_entries = '0;
            return;
        end
        if (b == CH_NL) begin
            emit_entry();
        end else begin
            case (ln_phase)
                PH_KEY: begin
                    if (b == CH_COLON) ln_phase = PH_SPACE;
                    else if (key_len + 1 >= KEY_MAX) ln_phase = PH_DISCARD;
                    else begin
                        key_buf[key_len] = b;
                        key_len++;
                    end
                end
                PH_SPACE: begin
                    if (b inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR}) ;
                    else if (b == CH_PLUS) ln_phase = PH_DIGITS;
                    else if (b == CH_MINUS) begin
                        acc_neg  = 1'b1;
                        ln_phase = PH_DIGITS;
                    end else if (b >= CH_ZERO && b <= CH_NINE) begin
                        add_digit(b);
                        ln_phase = PH_DIGITS;
                    end else ln_phase = PH_TAIL;
                end
                PH_DIGITS: begin
                    if (b >= CH_ZERO && b <= CH_NINE) add_digit(b);
                    else ln_phase = PH_TAIL;
                end
                default: ;
            endcase
        end
        if (eot) begin
            emit_entry();
            doc_entries = '0;
        end
    endfunction

    function void note_mismatch(input string what, input t_kv_chunk exp, input t_kv_chunk got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: exp key=%h n=%0d entry=%0d value=%h last=%b", $realtime, what,
                     exp.key, exp.nbytes, exp.entry, exp.value, exp.last);
            $display("%0t %s: got key=%h n=%0d entry=%0d value=%h last=%b", $realtime, what,
                     got.key, got.nbytes, got.entry, got.value, got.last);
        end
    endfunction

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d chunks outstanding", cycles,
                     expected_chunks.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // receive side: check each taken chunk, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rx_got.key    = m_axis_tdata[63:0];
            rx_got.nbytes = m_axis_tdata[67:64];
            rx_got.entry  = m_axis_tdata[77:68];
            rx_got.value  = m_axis_tdata[141:78];
            rx_got.last   = m_axis_tlast;
            chunks_checked++;
            if (expected_chunks.size() == 0) begin
                note_mismatch("unexpected chunk", '0, rx_got);
            end else begin
                rx_exp = expected_chunks.pop_front();
                if (rx_got !== rx_exp) note_mismatch("chunk mismatch", rx_exp, rx_got);
            end
        end
        m_axis_tready <= !hold_on && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // long receiver hold-off so the parser backs up into its input
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    task automatic send_text_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eot;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_text_byte(b, eot);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        while (expected_chunks.size() > 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        if (expected_chunks.size() > 0) begin
            $display("%0t %0d expected chunks never arrived", $realtime,
                     expected_chunks.size());
            mismatches += expected_chunks.size();
            expected_chunks.delete();
        end
    endtask

    task automatic write_entry_limit(input logic [LIMIT_W-1:0] lim);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        entry_limit = lim;
    endtask

    function logic [7:0] rand_key_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0) return 8'h61 + 8'($urandom_range(0, 25));
        c = 8'($urandom_range(1, 255));
        if (c == CH_NL || c == CH_COLON) c = 8'h5f;
        return c;
    endfunction

    function void build_line();
        int pick;
        int n;
        logic [7:0] c;
        line_buf.delete();
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 34) : $urandom_range(0, 12);
            repeat (n) line_buf.push_back(rand_key_char());
            line_buf.push_back(CH_COLON);
            repeat ($urandom_range(0, 2)) line_buf.push_back(ws_set[$urandom_range(0, 4)]);
            case ($urandom_range(0, 3))
                0: line_buf.push_back(CH_PLUS);
                1: line_buf.push_back(CH_MINUS);
                default: ;
            endcase
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(19, 22) : $urandom_range(0, 8);
            repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    c = 8'($urandom_range(1, 255));
                    line_buf.push_back(c == CH_NL ? CH_COLON : c);
                end
            end
            line_buf.push_back(CH_NL);
        end else if (pick < 85) begin
            repeat ($urandom_range(0, 10)) line_buf.push_back(rand_key_char());
            line_buf.push_back(CH_NL);
        end else if (pick < 92) begin
            line_buf.push_back(CH_NL);
        end else begin
            repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(1, 255)));
        end
    endfunction

    task automatic send_random_lines(input int n_bytes, input int min_chunks);
        int start_bytes;
        int start_chunks;
        int doc_end;
        start_bytes  = bytes_sent;
        start_chunks = chunks_predicted;
        while (bytes_sent - start_bytes < n_bytes ||
               chunks_predicted - start_chunks < min_chunks) begin
            build_line();
            doc_end = $urandom_range(0, 11);
            if (doc_end == 2 && line_buf.size() > 1 && line_buf[$] == CH_NL)
                void'(line_buf.pop_back());
            foreach (line_buf[i])
                send_text_byte(line_buf[i], doc_end == 1 && i == line_buf.size() - 1);
            if (doc_end == 0 || doc_end == 2)
                send_text_byte(CH_NUL, 1'($urandom_range(0, 1)));
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        entry_limit = LIMIT_RESET;
        doc_entries = '0;
        pin_set     = 1'b0;
        clear_line();
        send_idle_pct  = 8;
        recv_stall_pct = 73;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            pin_set = dir_rows[r].pinned;
            pin_chunk.key    = dir_rows[r].pin_key;
            pin_chunk.nbytes = dir_rows[r].pin_bytes;
            pin_chunk.value  = dir_rows[r].pin_value;
            for (int i = 0; i < dir_rows[r].text.len(); i++)
                send_text_byte(dir_rows[r].text[i],
                               dir_rows[r].eot && i == dir_rows[r].text.len() - 1);
            if (dir_rows[r].close_doc) send_text_byte(CH_NUL, 1'b0);
            pin_set = 1'b0;
        end
        s_axis_tvalid <= 1'b0;

        write_entry_limit(11'd1);
        send_random_lines(15, 0);
        write_entry_limit(11'd0);
        send_random_lines(10, 0);

        send_idle_pct  = 73;
        recv_stall_pct = 8;
        write_entry_limit(11'd5);
        send_random_lines(30, 0);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_entry_limit(11'd1024);
        hold_go = 1'b1;
        repeat (FILL_LINES) begin
            send_text_byte(CH_COLON, 1'b0);
            send_text_byte(CH_NL, 1'b0);
        end
        send_text_byte(CH_NUL, 1'b0);
        send_random_lines(15, 0);

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("sent %0d text bytes over entry limits 64, 1, 0, 5 and 1024", bytes_sent);
        $display("checked %0d key chunks with sender and receiver stalls and a long hold-off",
                 chunks_checked);
        if (mismatches == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/kvlp_pkg.sv
hdl/key_value_line_parser.sv
test/tb.sv
